### rtl/cdq_pkg.sv
// shared types and codes for the circular deque
package cdq_pkg;

    typedef enum logic [2:0] {
        FN_PUSH_BACK  = 3'd0,
        FN_POP_FRONT  = 3'd1,
        FN_PUSH_FRONT = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_CLEAR      = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_OUT  = 2'b10
    } t_state;

endpackage

### rtl/circular_deque.sv
// circular deque top level: pointer and count control around the slot ram
// a result is valid in the cycle after its transaction is accepted
// one transaction is taken per cycle while results are taken at once;
//   the slot ram's registered read port gives the popped value with the result
// reset: synchronous active low, clears pointers, count and handshake state,
//   capacity returns to DEPTH; slot contents are left as they are
module circular_deque #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [$clog2(DEPTH+1)-1:0]   i_cfg_capacity,
    // operation in
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [2:0]                   i_func,
    input  logic [DATA_WIDTH-1:0]        i_data_in,
    // result out
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [DATA_WIDTH-1:0]        o_data_out,
    output logic [1:0]                   o_status,
    output logic [$clog2(DEPTH+1)-1:0]   o_length,
    output logic                         o_is_empty,
    output logic                         o_is_full
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cdq_pkg::t_state  r_state;
    logic [CNT_W-1:0] r_cap;
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;

    cdq_pkg::t_status r_status, n_status;
    logic             r_pop_ok, n_pop_ok;
    logic [CNT_W-1:0] r_len;
    logic             r_empty;
    logic             r_full;

    logic             in_acc;
    logic             out_acc;
    cdq_pkg::t_func   fn;
    logic [CNT_W-1:0] cap_eff;
    logic             is_full_now;
    logic [CNT_W-1:0] head_x, tail_x;
    logic [CNT_W-1:0] tail_next, head_prev, head_next, tail_prev;

    logic                  mem_we, mem_re;
    logic [IDX_W-1:0]      mem_waddr, mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    assign in_acc      = i_valid && o_ready;
    assign out_acc     = o_valid && i_ready;
    assign o_ready     = (r_state == cdq_pkg::S_IDLE) || i_ready;
    assign o_valid     = (r_state == cdq_pkg::S_OUT);
    assign o_cfg_ready = 1'b1;
    assign fn          = cdq_pkg::t_func'(i_func);

    // capacity 0 acts as 1, above DEPTH acts as DEPTH
    always_comb begin
        priority if (r_cap == '0) begin
            cap_eff = CNT_W'(1);
        end else if (r_cap > CNT_W'(DEPTH)) begin
            cap_eff = CNT_W'(DEPTH);
        end else begin
            cap_eff = r_cap;
        end
    end

    assign is_full_now = (r_count >= cap_eff);
    assign head_x      = CNT_W'(r_head);
    assign tail_x      = CNT_W'(r_tail);

    // wrap at the effective capacity; a pointer above it after a capacity
    // change steps back to the last slot, or forward to slot 0
    assign tail_next = ((tail_x + CNT_W'(1)) >= cap_eff) ? '0 : tail_x + CNT_W'(1);
    assign head_next = ((head_x + CNT_W'(1)) >= cap_eff) ? '0 : head_x + CNT_W'(1);
    assign head_prev = ((head_x == '0) || (head_x > cap_eff)) ? cap_eff - CNT_W'(1)
                                                              : head_x - CNT_W'(1);
    assign tail_prev = ((tail_x == '0) || (tail_x > cap_eff)) ? cap_eff - CNT_W'(1)
                                                              : tail_x - CNT_W'(1);

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_status  = cdq_pkg::ST_OK;
        n_pop_ok  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_re    = 1'b0;
        mem_raddr = r_head;
        unique case (fn)
            cdq_pkg::FN_PUSH_BACK, cdq_pkg::FN_PUSH_FRONT: begin
                if (is_full_now) begin
                    n_status = cdq_pkg::ST_FULL;
                end else begin
                    mem_we  = in_acc;
                    n_count = r_count + CNT_W'(1);
                    priority if (r_count == '0) begin
                        n_head    = '0;
                        n_tail    = '0;
                        mem_waddr = '0;
                    end else if (fn == cdq_pkg::FN_PUSH_BACK) begin
                        n_tail    = tail_next[IDX_W-1:0];
                        mem_waddr = tail_next[IDX_W-1:0];
                    end else begin
                        n_head    = head_prev[IDX_W-1:0];
                        mem_waddr = head_prev[IDX_W-1:0];
                    end
                end
            end
            cdq_pkg::FN_POP_FRONT, cdq_pkg::FN_POP_BACK: begin
                if (r_count == '0) begin
                    n_status = cdq_pkg::ST_EMPTY;
                end else begin
                    n_pop_ok  = 1'b1;
                    mem_re    = in_acc;
                    mem_raddr = (fn == cdq_pkg::FN_POP_FRONT) ? r_head : r_tail;
                    n_count   = r_count - CNT_W'(1);
                    priority if (r_count == CNT_W'(1)) begin
                        n_head = '0;
                        n_tail = '0;
                    end else if (fn == cdq_pkg::FN_POP_FRONT) begin
                        n_head = head_next[IDX_W-1:0];
                    end else begin
                        n_tail = tail_prev[IDX_W-1:0];
                    end
                end
            end
            cdq_pkg::FN_CLEAR: begin
                n_count = '0;
                n_head  = '0;
                n_tail  = '0;
            end
            default: begin
                // unused operation codes leave everything as it is
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdq_pkg::S_IDLE;
            r_cap   <= CNT_W'(DEPTH);
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_capacity;
            end
            if (in_acc) begin
                r_state <= cdq_pkg::S_OUT;
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end else if (out_acc) begin
                r_state <= cdq_pkg::S_IDLE;
            end
        end
    end

    // result fields, loaded with each transaction
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status <= n_status;
            r_pop_ok <= n_pop_ok;
            r_len    <= n_count;
            r_empty  <= (n_count == '0);
            r_full   <= (n_count >= cap_eff);
        end
    end

    cdq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_data_in),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_data_out = r_pop_ok ? mem_rdata : '0;
    assign o_status   = r_status;
    assign o_length   = r_len;
    assign o_is_empty = r_empty;
    assign o_is_full  = r_full;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("element count above depth");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_length == '0)))
        else $error("empty flag disagrees with length");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != cdq_pkg::ST_OK)) |-> (o_data_out == '0))
        else $error("refused transaction returned data");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (fn == cdq_pkg::FN_CLEAR)) |=>
            ((r_count == '0) && (r_head == '0) && (r_tail == '0)))
        else $error("clear did not reset pointers and count");

    a_pop_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && n_pop_ok) |=> (o_length == $past(r_count) - CNT_W'(1)))
        else $error("pop did not reduce length by one");
`endif

endmodule

### rtl/cdq_ram.sv
// slot storage: one write port, one registered read port
module cdq_ram #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_WIDTH-1:0]    i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_WIDTH-1:0]    o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
